### sv/mdss_pkg.sv
// Shared types and constants for the minimum delete-sum block.
package mdss_pkg;

    localparam int DEFAULT_MAX_LEN = 64;
    localparam int CHAR_W          = 8;
    localparam int SUM_W           = 15;
    localparam int SUM_SAT         = 32767;
    localparam int CMD_W           = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND_FIRST  = 2'd0,
        CMD_APPEND_SECOND = 2'd1,
        CMD_FINISH        = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_FILL_A,
        ST_FILL_B,
        ST_ROW_A,
        ST_ROW_B,
        ST_CELL_A,
        ST_CELL_B
    } state_t;

    // Separate encoding keeps the result wait out of the sweep states.
    typedef enum logic {
        OUT_SWEEP,
        OUT_RESULT
    } phase_t;

endpackage

### sv/mdss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mdss_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/min_delete_sum_two_strings_top.sv
// Minimum ASCII delete-sum of two byte strings, loaded a character at a time.
//
// Input channel (s_): s_tuser carries the command, s_tdata the character byte.
// Append commands are accepted back to back while the block is idle; a
// character beyond MAX_LEN characters in a string is dropped and flagged.
// A finish word starts a sweep of the weighted edit-distance table, kept as
// one rolling row in a RAM. Each table cell passes through the shared
// adder/compare unit in ST_CELL_A (the registered RAM reads) and then ST_CELL_B
// (add, compare and write back); a finish holds s_tready low through the sweep
// and the result load, and m_tvalid rises in the same cycle that s_tready
// returns high.
// s_tready stays low for the whole sweep.
// Output channel (m_): m_tdata carries delete_sum, m_tuser the too_long flag.
// The result sits in an output register; appends keep flowing while it waits,
// and only the next finish holds off at the end of its sweep until the
// receiver takes the earlier result.
// Reset (aresetn low, synchronous) empties both strings, clears the overflow
// flag and drops any pending result. The RAMs need no clearing pass.
module min_delete_sum_two_strings_top
    import mdss_pkg::*;
#(
    parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [14:0] delete_sum, [15] zero
    output logic        m_tuser    // [0] too_long
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int ROW_W  = $clog2(2 * 255 * MAX_LEN + 1);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [CNT_W-1:0]  cnt1_reg, cnt1_next;
    logic [CNT_W-1:0]  cnt2_reg, cnt2_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CHAR_W-1:0] a_reg, a_next;
    logic [ROW_W-1:0]  left_reg, left_next;
    logic [ROW_W-1:0]  diag_reg, diag_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              too_long_reg, too_long_next;

    logic              s1_we, s2_we, row_we;
    logic [ADDR_W-1:0] s1_waddr, s2_waddr, s1_raddr, s2_raddr;
    logic [CHAR_W-1:0] s1_rdata, s2_rdata;
    logic [CNT_W-1:0]  row_waddr, row_raddr;
    logic [ROW_W-1:0]  row_wdata, row_rdata;

    logic [CNT_W-1:0]  i_m1, j_m1;
    logic [ROW_W-1:0]  del_first, del_second, cell_val, row0_val, fill_val;
    logic [31:0]       left_ext;
    logic              s_take;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_take   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, sum_reg};
    assign m_tuser  = too_long_reg;

    assign i_m1 = i_reg - CNT_W'(1);
    assign j_m1 = j_reg - CNT_W'(1);

    // Shared unit: one add pair, one compare, one select; column zero has its own adder.
    assign del_first  = row_rdata + ROW_W'(a_reg);
    assign del_second = left_reg + ROW_W'(s2_rdata);
    assign cell_val   = (a_reg == s2_rdata) ? diag_reg :
                        ((del_first < del_second) ? del_first : del_second);
    assign row0_val   = row_rdata + ROW_W'(s1_rdata);
    assign fill_val   = del_second;
    assign left_ext   = 32'(left_reg);

    assign s1_waddr = cnt1_reg[ADDR_W-1:0];
    assign s2_waddr = cnt2_reg[ADDR_W-1:0];
    assign s1_raddr = i_m1[ADDR_W-1:0];
    assign s2_raddr = j_m1[ADDR_W-1:0];

    mdss_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_ram (
        .aclk  (aclk),
        .we    (s1_we),
        .waddr (s1_waddr),
        .wdata (s_tdata),
        .raddr (s1_raddr),
        .rdata (s1_rdata)
    );

    mdss_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_ram (
        .aclk  (aclk),
        .we    (s2_we),
        .waddr (s2_waddr),
        .wdata (s_tdata),
        .raddr (s2_raddr),
        .rdata (s2_rdata)
    );

    mdss_ram #(.WIDTH(ROW_W), .DEPTH(MAX_LEN + 1)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cnt1_next     = cnt1_reg;
        cnt2_next     = cnt2_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        a_next        = a_reg;
        left_next     = left_reg;
        diag_next     = diag_reg;
        sum_next      = sum_reg;
        too_long_next = too_long_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s1_we         = 1'b0;
        s2_we         = 1'b0;
        row_we        = 1'b0;
        row_waddr     = j_reg;
        row_wdata     = cell_val;
        row_raddr     = j_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    unique case (cmd_t'(s_tuser))
                        CMD_APPEND_FIRST: begin
                            if (cnt1_reg < CNT_W'(MAX_LEN)) begin
                                s1_we     = 1'b1;
                                cnt1_next = cnt1_reg + CNT_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_APPEND_SECOND: begin
                            if (cnt2_reg < CNT_W'(MAX_LEN)) begin
                                s2_we     = 1'b1;
                                cnt2_next = cnt2_reg + CNT_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_FINISH: begin
                            state_next = ST_INIT;
                            phase_next = OUT_SWEEP;
                        end
                        default: begin
                            // unused command: drop the word
                        end
                    endcase
                end
            end
            ST_INIT: begin
                row_we    = 1'b1;
                row_waddr = '0;
                row_wdata = '0;
                left_next = '0;
                i_next    = CNT_W'(1);
                j_next    = CNT_W'(1);
                if (cnt2_reg != '0) begin
                    state_next = ST_FILL_A;
                end else if (cnt1_reg != '0) begin
                    state_next = ST_ROW_A;
                end else begin
                    phase_next = OUT_RESULT;
                    state_next = ST_CELL_B;
                end
            end
            ST_FILL_A: begin
                state_next = ST_FILL_B;
            end
            ST_FILL_B: begin
                row_we    = 1'b1;
                row_wdata = fill_val;
                left_next = fill_val;
                if (j_reg == cnt2_reg) begin
                    if (cnt1_reg != '0) begin
                        state_next = ST_ROW_A;
                    end else begin
                        phase_next = OUT_RESULT;
                        state_next = ST_CELL_B;
                    end
                end else begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = ST_FILL_A;
                end
            end
            ST_ROW_A: begin
                row_raddr  = '0;
                state_next = ST_ROW_B;
            end
            ST_ROW_B: begin
                a_next    = s1_rdata;
                diag_next = row_rdata;
                row_we    = 1'b1;
                row_waddr = '0;
                row_wdata = row0_val;
                left_next = row0_val;
                j_next    = CNT_W'(1);
                if (cnt2_reg != '0) begin
                    state_next = ST_CELL_A;
                end else if (i_reg == cnt1_reg) begin
                    phase_next = OUT_RESULT;
                    state_next = ST_CELL_B;
                end else begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_ROW_A;
                end
            end
            ST_CELL_A: begin
                state_next = ST_CELL_B;
            end
            ST_CELL_B: begin
                if (phase_reg == OUT_RESULT) begin
                    // left_reg holds the last entry of the final row
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_next = 1'b1;
                        sum_next      = (left_ext > 32'(SUM_SAT)) ? SUM_W'(SUM_SAT)
                                                                  : SUM_W'(left_ext);
                        too_long_next = ovf_reg;
                        cnt1_next     = '0;
                        cnt2_next     = '0;
                        ovf_next      = 1'b0;
                        phase_next    = OUT_SWEEP;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    row_we    = 1'b1;
                    row_wdata = cell_val;
                    left_next = cell_val;
                    diag_next = row_rdata;
                    if (j_reg == cnt2_reg) begin
                        if (i_reg == cnt1_reg) begin
                            phase_next = OUT_RESULT;
                            state_next = ST_CELL_B;
                        end else begin
                            i_next     = i_reg + CNT_W'(1);
                            state_next = ST_ROW_A;
                        end
                    end else begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = ST_CELL_A;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= OUT_SWEEP;
            cnt1_reg     <= '0;
            cnt2_reg     <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt1_reg     <= cnt1_next;
            cnt2_reg     <= cnt2_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        a_reg        <= a_next;
        left_reg     <= left_next;
        diag_reg     <= diag_next;
        sum_reg      <= sum_next;
        too_long_reg <= too_long_next;
    end

endmodule

### sv/mdss_checker.sv
// Port-level assertions for the delete-sum block, bound to the top level.
module mdss_checker
    import mdss_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A pending result holds until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Only a finish word starts a sweep.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tready && s_tuser == CMD_FINISH))
        else $error("input stalled without a finish word");

    // Appends never stall the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != CMD_FINISH |=> s_tready)
        else $error("input stalled after an append word");

    // A new result comes with the block back to accepting words.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready && !$past(s_tready))
        else $error("result appeared outside the end of a sweep");

    // Reset drops any pending result.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind min_delete_sum_two_strings_top mdss_checker u_mdss_checker (.*);
